>>> rtl/sfdl_pkg.sv
`default_nettype none

package sfdl_pkg;

    localparam int DEPTH_LOG2   = 17;
    localparam int STORE_DEPTH  = 1 << DEPTH_LOG2;
    localparam int SMOOTH_SHIFT = 10;
    localparam int TANH_LOG2    = 10;
    localparam int TANH_DEPTH   = 1 << TANH_LOG2;

    localparam int SAMPLE_W  = 24;
    localparam int REG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int POS_W     = DEPTH_LOG2 + 16;
    localparam int DELAY_W   = POS_W + 1;
    localparam int TANH_W    = 21;
    localparam int MUL_W     = 27;
    localparam int ACC_W     = 64;
    localparam int GAIN_W    = 34;
    localparam int STEP_W    = 19;
    localparam int CLIP_W    = 26;
    localparam int INTERP_W  = 22;

    localparam int CLIP_SHIFT  = 23;
    localparam int LUT_FRAC_W  = CLIP_SHIFT - TANH_LOG2;
    localparam int STEP_LIMIT  = 2 << 16;
    localparam int OUT_LIMIT   = 4 << 20;
    localparam int ONE_Q20     = 1 << 20;
    localparam int FB_GAIN     = 72058;
    localparam int MIX_SHIFT   = 21;

    // Short range target is reg * STORE_DEPTH / 100, taken as a multiply by a
    // rounded-up reciprocal of 25 over the depth divided by four.
    localparam int DIV_SHIFT = 21;
    localparam longint unsigned DIV_RECIP =
        ((64'd1 << (DEPTH_LOG2 - 2 + DIV_SHIFT)) + 64'd24) / 64'd25;
    localparam int RECIP_LO = int'(DIV_RECIP & 64'hFFFF);
    localparam int RECIP_HI = int'(DIV_RECIP >> 16);

    localparam logic [REG_W-1:0] REG_HALF = 16'h8000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DELAY_LEFT  = 3'd0,
        CFG_DELAY_RIGHT = 3'd1,
        CFG_SHORT_RANGE = 3'd2,
        CFG_FEEDBACK    = 3'd3,
        CFG_WET_MIX     = 3'd4,
        CFG_OUT_LEVEL   = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        SH_NONE = 2'd0,
        SH_WORD = 2'd1,
        SH_MIX  = 2'd2
    } t_mac_sh;

    typedef struct packed {
        logic                    valid;
        logic                    clr;
        t_mac_sh                 sh;
        logic signed [MUL_W-1:0] a;
        logic signed [MUL_W-1:0] b;
    } t_mac_op;

    typedef logic [TANH_W-1:0] t_tanh_tab [TANH_DEPTH+1];

    // Unsigned quotient by shift and subtract, used while the table is built.
    function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[63:0], n[b]};
            if (r >= {1'b0, d}) begin
                r    = r - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Each entry is tanh on [0, 8.0] in Q.20: exp(-2x/16) by a Taylor series
    // in Q.31, squared four times, then (1 - e) / (1 + e) rounded.
    function automatic t_tanh_tab tanh_table();
        t_tanh_tab       tab;
        logic [63:0]     g;
        logic [63:0]     term;
        logic [63:0]     e;
        logic [63:0]     num;
        logic [63:0]     den;
        longint          sum;
        for (int i = 0; i <= TANH_DEPTH; i++) begin
            g    = (64'(i) << (35 - TANH_LOG2)) >> 4;
            term = 64'd1 << 31;
            sum  = longint'(term);
            for (int k = 1; k <= 14; k++) begin
                term = udiv64((term * g) >> 31, 64'(k));
                if ((k & 1) == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            e = 64'(sum);
            if (e > (64'd1 << 31)) begin
                e = 64'd1 << 31;
            end
            for (int k = 0; k < 4; k++) begin
                e = (e * e) >> 31;
            end
            num    = ((64'd1 << 31) - e) << 20;
            den    = (64'd1 << 31) + e;
            tab[i] = TANH_W'(udiv64(num + (den >> 1), den));
        end
        return tab;
    endfunction

endpackage

`default_nettype wire

>>> rtl/sfdl_in_if.sv
`default_nettype none

interface sfdl_in_if;
    import sfdl_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_left;
    logic signed [SAMPLE_W-1:0] sample_right;

    modport source (output valid, output sample_left, output sample_right, input ready);
    modport sink (input valid, input sample_left, input sample_right, output ready);
endinterface

`default_nettype wire

>>> rtl/sfdl_out_if.sv
`default_nettype none

interface sfdl_out_if;
    import sfdl_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] out_left;
    logic signed [SAMPLE_W-1:0] out_right;

    modport source (output valid, output out_left, output out_right, input ready);
    modport sink (input valid, input out_left, input out_right, output ready);
endinterface

`default_nettype wire

>>> rtl/sfdl_mac.sv
`default_nettype none

module sfdl_mac (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  sfdl_pkg::t_mac_op                    i_op,
    output logic signed [sfdl_pkg::ACC_W-1:0]    o_acc
);
    import sfdl_pkg::*;

    logic                      r_vld;
    logic                      r_clr;
    t_mac_sh                   r_sh;
    logic signed [2*MUL_W-1:0] r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [ACC_W-1:0]   addend;
    logic signed [ACC_W-1:0]   n_acc;

    always_comb begin
        case (r_sh)
            SH_WORD: addend = ACC_W'(r_prod) << 16;
            SH_MIX:  addend = ACC_W'(r_prod) << MIX_SHIFT;
            default: addend = ACC_W'(r_prod);
        endcase
        n_acc = (r_clr ? '0 : r_acc) + addend;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_op.valid;
        end
        r_clr  <= i_op.clr;
        r_sh   <= i_op.sh;
        r_prod <= i_op.a * i_op.b;
        if (r_vld) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule

`default_nettype wire

>>> rtl/sfdl_store.sv
`default_nettype none

module sfdl_store (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [sfdl_pkg::DEPTH_LOG2-1:0]       i_waddr,
    input  logic signed [sfdl_pkg::SAMPLE_W-1:0]  i_wdata,
    input  logic [sfdl_pkg::DEPTH_LOG2-1:0]       i_raddr,
    output logic signed [sfdl_pkg::SAMPLE_W-1:0]  o_rdata
);
    import sfdl_pkg::*;

    logic signed [SAMPLE_W-1:0] r_mem [STORE_DEPTH];
    logic signed [SAMPLE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/sfdl_tanh_rom.sv
`default_nettype none

module sfdl_tanh_rom (
    input  logic                           i_clk,
    input  logic [sfdl_pkg::TANH_LOG2-1:0] i_addr,
    output logic [sfdl_pkg::TANH_W-1:0]    o_lo,
    output logic [sfdl_pkg::TANH_W-1:0]    o_hi
);
    import sfdl_pkg::*;

    localparam t_tanh_tab TANH_TAB = tanh_table();

    logic [TANH_LOG2:0] addr_lo;
    logic [TANH_LOG2:0] addr_hi;
    logic [TANH_W-1:0]  r_lo;
    logic [TANH_W-1:0]  r_hi;

    assign addr_lo = {1'b0, i_addr};
    assign addr_hi = addr_lo + 1'b1;

    always_ff @(posedge i_clk) begin
        r_lo <= TANH_TAB[addr_lo];
        r_hi <= TANH_TAB[addr_hi];
    end

    assign o_lo = r_lo;
    assign o_hi = r_hi;

endmodule

`default_nettype wire

>>> rtl/stereo_feedback_delay_line.sv
// Stereo feedback delay line with a smoothed fractional tap and tanh soft clip.
// Items arrive on i_in (one stereo Q3.20 pair) and leave on o_out, both with
// valid/ready; an item moves when valid and ready are high at a clock edge.
// Registers are written through i_cfg_we/i_cfg_idx/i_cfg_wdata, one per cycle.
// After reset the block sweeps both delay stores to zero, one entry per cycle,
// and i_in.ready stays low meanwhile.
// Each item is worked by one shared multiply-accumulate unit under a
// sequencer: a set-up phase that forms the feedback gain, a pass for each
// channel, left then right, then a state that loads the output register; a new
// item is taken only once the result of the last one has been loaded.
// The length of each pass is set by the number of multiplies per channel and
// the latency of the shared unit.
// The result waits in an output register while o_out.ready is low; the next
// item is accepted and worked meanwhile, and the block holds before loading its
// result until the register is free.
`default_nettype none

module stereo_feedback_delay_line (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [sfdl_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [sfdl_pkg::REG_W-1:0]       i_cfg_wdata,
    sfdl_in_if.sink                          i_in,
    sfdl_out_if.source                       o_out
);
    import sfdl_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_GAIN, S_GAIN_W, S_GAIN_SET,
        S_TGT_H, S_TGT_L, S_TGT_W, S_STEP, S_CUR, S_ADDR,
        S_RD0, S_RD1, S_TAP_W, S_FB_H, S_FB_L, S_FB_W,
        S_CLIP, S_LUT, S_LUT_W, S_WR, S_MIX_L, S_MIX_W,
        S_OUT_H, S_OUT_L, S_OUT_W, S_OUT_F, S_DONE
    } t_state;

    t_state r_state;

    logic [REG_W-1:0] r_delay_l;
    logic [REG_W-1:0] r_delay_r;
    logic             r_short;
    logic [REG_W-1:0] r_fb;
    logic [REG_W-1:0] r_wet;
    logic [REG_W-1:0] r_level;

    logic                         r_ch;
    logic [DEPTH_LOG2-1:0]        r_clr_cnt;
    logic [DEPTH_LOG2-1:0]        r_wp;
    logic [DELAY_W-1:0]           r_cur_l;
    logic [DELAY_W-1:0]           r_cur_r;
    logic signed [SAMPLE_W-1:0]   r_in_l;
    logic signed [SAMPLE_W-1:0]   r_in_r;
    logic [GAIN_W-1:0]            r_g;
    logic signed [STEP_W-1:0]     r_step;
    logic [15:0]                  r_frac;
    logic [DEPTH_LOG2-1:0]        r_nxt;
    logic signed [SAMPLE_W:0]     r_tap;
    logic [LUT_FRAC_W-1:0]        r_m13;
    logic                         r_neg;
    logic                         r_big;
    logic [TANH_W-1:0]            r_t0;
    logic [MIX_SHIFT-1:0]         r_vl;
    logic signed [SAMPLE_W-1:0]   r_res_l;
    logic                         r_ovalid;
    logic signed [SAMPLE_W-1:0]   r_out_l;
    logic signed [SAMPLE_W-1:0]   r_out_r;

    t_mac_op                      mac_op;
    logic signed [ACC_W-1:0]      acc;

    logic [REG_W-1:0]             sel_reg;
    logic [DELAY_W-1:0]           sel_cur;
    logic signed [SAMPLE_W-1:0]   sel_in;
    logic signed [SAMPLE_W-1:0]   sel_rd;
    logic signed [SAMPLE_W-1:0]   rd_l;
    logic signed [SAMPLE_W-1:0]   rd_r;

    logic [POS_W-1:0]             tgt;
    logic signed [DELAY_W:0]      diff;
    logic signed [DELAY_W:0]      step_raw;
    logic signed [STEP_W-1:0]     step_c;
    logic signed [DELAY_W:0]      cur_sum;
    logic [DELAY_W-1:0]           cur_new;
    logic [POS_W-1:0]             pos;
    logic signed [SAMPLE_W:0]     tap_c;
    logic signed [CLIP_W-1:0]     x_c;
    logic [CLIP_W-1:0]            mag;
    logic [TANH_W-1:0]            t0;
    logic [TANH_W-1:0]            t1;
    logic signed [INTERP_W-1:0]   interp;
    logic signed [INTERP_W-1:0]   clip_r;
    logic signed [INTERP_W-1:0]   clip_v;
    logic signed [ACC_W-1:0]      out_full;
    logic signed [SAMPLE_W-1:0]   out_sat;
    logic                         out_load;

    logic                         st_we_l;
    logic                         st_we_r;
    logic [DEPTH_LOG2-1:0]        st_waddr;
    logic signed [SAMPLE_W-1:0]   st_wdata;
    logic [DEPTH_LOG2-1:0]        st_raddr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_l <= REG_HALF;
            r_delay_r <= REG_HALF;
            r_short   <= 1'b0;
            r_fb      <= '0;
            r_wet     <= REG_HALF;
            r_level   <= REG_HALF;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_DELAY_LEFT:  r_delay_l <= i_cfg_wdata;
                CFG_DELAY_RIGHT: r_delay_r <= i_cfg_wdata;
                CFG_SHORT_RANGE: r_short   <= i_cfg_wdata[0];
                CFG_FEEDBACK:    r_fb      <= i_cfg_wdata;
                CFG_WET_MIX:     r_wet     <= i_cfg_wdata;
                CFG_OUT_LEVEL:   r_level   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        sel_reg = r_ch ? r_delay_r : r_delay_l;
        sel_cur = r_ch ? r_cur_r : r_cur_l;
        sel_in  = r_ch ? r_in_r : r_in_l;
        sel_rd  = r_ch ? rd_r : rd_l;

        tgt = r_short ? acc[DIV_SHIFT +: POS_W] : {sel_reg, {DEPTH_LOG2{1'b0}}};
        if (tgt == '0) begin
            tgt = POS_W'(1);
        end
        diff     = $signed({2'b00, tgt}) - $signed({1'b0, sel_cur});
        step_raw = diff >>> SMOOTH_SHIFT;
        if (step_raw > STEP_LIMIT) begin
            step_c = STEP_W'(STEP_LIMIT);
        end else if (step_raw < -STEP_LIMIT) begin
            step_c = STEP_W'(-STEP_LIMIT);
        end else begin
            step_c = STEP_W'(step_raw);
        end
        cur_sum = $signed({1'b0, sel_cur}) + (DELAY_W+1)'(r_step);
        cur_new = (cur_sum < 0) ? '0 : cur_sum[DELAY_W-1:0];

        pos   = {r_wp, 16'h0000} - sel_cur[POS_W-1:0];
        tap_c = (SAMPLE_W+1)'(acc >>> 16);

        x_c = CLIP_W'(sel_in) + CLIP_W'(acc >>> 32);
        mag = x_c[CLIP_W-1] ? CLIP_W'(-x_c) : CLIP_W'(x_c);

        interp = $signed({1'b0, r_t0}) + INTERP_W'(acc >>> LUT_FRAC_W);
        clip_r = r_big ? INTERP_W'(ONE_Q20) : interp;
        clip_v = r_neg ? -clip_r : clip_r;

        out_full = acc >>> 31;
        if (out_full > OUT_LIMIT) begin
            out_sat = SAMPLE_W'(OUT_LIMIT);
        end else if (out_full < -OUT_LIMIT) begin
            out_sat = SAMPLE_W'(-OUT_LIMIT);
        end else begin
            out_sat = SAMPLE_W'(out_full);
        end

        out_load = (r_state == S_DONE) && (!r_ovalid || o_out.ready);

        st_we_l  = (r_state == S_CLEAR) || ((r_state == S_WR) && !r_ch);
        st_we_r  = (r_state == S_CLEAR) || ((r_state == S_WR) && r_ch);
        st_waddr = (r_state == S_CLEAR) ? r_clr_cnt : r_wp;
        st_wdata = (r_state == S_CLEAR) ? '0 : SAMPLE_W'(clip_v);
        st_raddr = (r_state == S_ADDR) ? pos[POS_W-1:16] : r_nxt;
    end

    always_comb begin
        mac_op       = '0;
        mac_op.sh    = SH_NONE;
        unique case (r_state)
            S_GAIN: begin
                mac_op = '{valid: 1'b1, clr: 1'b1, sh: SH_NONE,
                           a: MUL_W'($signed({1'b0, r_fb})), b: MUL_W'(FB_GAIN)};
            end
            S_TGT_H: begin
                mac_op = '{valid: 1'b1, clr: 1'b1, sh: SH_WORD,
                           a: MUL_W'($signed({1'b0, sel_reg})), b: MUL_W'(RECIP_HI)};
            end
            S_TGT_L: begin
                mac_op = '{valid: 1'b1, clr: 1'b0, sh: SH_NONE,
                           a: MUL_W'($signed({1'b0, sel_reg})), b: MUL_W'(RECIP_LO)};
            end
            S_RD0: begin
                mac_op = '{valid: 1'b1, clr: 1'b1, sh: SH_NONE, a: MUL_W'(sel_rd),
                           b: MUL_W'($signed({1'b0, 17'h10000 - {1'b0, r_frac}}))};
            end
            S_RD1: begin
                mac_op = '{valid: 1'b1, clr: 1'b0, sh: SH_NONE, a: MUL_W'(sel_rd),
                           b: MUL_W'($signed({1'b0, r_frac}))};
            end
            S_FB_H: begin
                mac_op = '{valid: 1'b1, clr: 1'b1, sh: SH_WORD, a: MUL_W'(tap_c),
                           b: MUL_W'($signed({1'b0, r_g[GAIN_W-1:16]}))};
            end
            S_FB_L: begin
                mac_op = '{valid: 1'b1, clr: 1'b0, sh: SH_NONE, a: MUL_W'(r_tap),
                           b: MUL_W'($signed({1'b0, r_g[15:0]}))};
            end
            S_LUT: begin
                mac_op = '{valid: 1'b1, clr: 1'b1, sh: SH_NONE,
                           a: MUL_W'($signed({1'b0, t1}) - $signed({1'b0, t0})),
                           b: MUL_W'($signed({1'b0, r_m13}))};
            end
            S_WR: begin
                mac_op = '{valid: 1'b1, clr: 1'b1, sh: SH_NONE, a: MUL_W'(sel_in),
                           b: MUL_W'($signed({1'b0, 17'h10000 - {1'b0, r_wet}}))};
            end
            S_MIX_L: begin
                mac_op = '{valid: 1'b1, clr: 1'b0, sh: SH_NONE, a: MUL_W'(r_tap),
                           b: MUL_W'($signed({1'b0, r_wet}))};
            end
            S_OUT_H: begin
                mac_op = '{valid: 1'b1, clr: 1'b1, sh: SH_MIX,
                           a: MUL_W'(acc >>> MIX_SHIFT),
                           b: MUL_W'($signed({1'b0, r_level}))};
            end
            S_OUT_L: begin
                mac_op = '{valid: 1'b1, clr: 1'b0, sh: SH_NONE,
                           a: MUL_W'($signed({1'b0, r_vl})),
                           b: MUL_W'($signed({1'b0, r_level}))};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_cnt <= '0;
            r_wp      <= '0;
            r_cur_l   <= '0;
            r_cur_r   <= '0;
            r_ch      <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            if (o_out.ready && !out_load) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_cnt <= r_clr_cnt + 1'b1;
                    if (r_clr_cnt == {DEPTH_LOG2{1'b1}}) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_in_l  <= i_in.sample_left;
                        r_in_r  <= i_in.sample_right;
                        r_ch    <= 1'b0;
                        r_state <= S_GAIN;
                    end
                end
                S_GAIN:     r_state <= S_GAIN_W;
                S_GAIN_W:   r_state <= S_GAIN_SET;
                S_GAIN_SET: begin
                    r_g     <= acc[GAIN_W-1:0];
                    r_state <= S_TGT_H;
                end
                S_TGT_H:    r_state <= S_TGT_L;
                S_TGT_L:    r_state <= S_TGT_W;
                S_TGT_W:    r_state <= S_STEP;
                S_STEP: begin
                    r_step  <= step_c;
                    r_state <= S_CUR;
                end
                S_CUR: begin
                    if (r_ch) begin
                        r_cur_r <= cur_new;
                    end else begin
                        r_cur_l <= cur_new;
                    end
                    r_state <= S_ADDR;
                end
                S_ADDR: begin
                    r_frac  <= pos[15:0];
                    r_nxt   <= pos[POS_W-1:16] + 1'b1;
                    r_state <= S_RD0;
                end
                S_RD0:      r_state <= S_RD1;
                S_RD1:      r_state <= S_TAP_W;
                S_TAP_W:    r_state <= S_FB_H;
                S_FB_H: begin
                    r_tap   <= tap_c;
                    r_state <= S_FB_L;
                end
                S_FB_L:     r_state <= S_FB_W;
                S_FB_W:     r_state <= S_CLIP;
                S_CLIP: begin
                    r_m13   <= mag[LUT_FRAC_W-1:0];
                    r_neg   <= x_c[CLIP_W-1];
                    r_big   <= (mag[CLIP_W-1:CLIP_SHIFT] != '0);
                    r_state <= S_LUT;
                end
                S_LUT: begin
                    r_t0    <= t0;
                    r_state <= S_LUT_W;
                end
                S_LUT_W:    r_state <= S_WR;
                S_WR:       r_state <= S_MIX_L;
                S_MIX_L:    r_state <= S_MIX_W;
                S_MIX_W:    r_state <= S_OUT_H;
                S_OUT_H: begin
                    r_vl    <= acc[MIX_SHIFT-1:0];
                    r_state <= S_OUT_L;
                end
                S_OUT_L:    r_state <= S_OUT_W;
                S_OUT_W:    r_state <= S_OUT_F;
                S_OUT_F: begin
                    if (r_ch) begin
                        r_state <= S_DONE;
                    end else begin
                        r_res_l <= out_sat;
                        r_ch    <= 1'b1;
                        r_state <= S_TGT_H;
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_out_l  <= r_res_l;
                        r_out_r  <= out_sat;
                        r_ovalid <= 1'b1;
                        r_wp     <= r_wp + 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default:    r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_ovalid;
    assign o_out.out_left  = r_out_l;
    assign o_out.out_right = r_out_r;

    sfdl_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (mac_op),
        .o_acc   (acc)
    );

    sfdl_store u_store_l (
        .i_clk   (i_clk),
        .i_we    (st_we_l),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (rd_l)
    );

    sfdl_store u_store_r (
        .i_clk   (i_clk),
        .i_we    (st_we_r),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (rd_r)
    );

    sfdl_tanh_rom u_tanh (
        .i_clk  (i_clk),
        .i_addr (mag[CLIP_SHIFT-1:LUT_FRAC_W]),
        .o_lo   (t0),
        .o_hi   (t1)
    );

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state == S_GAIN))
        else $error("An accepted item did not start the sequencer.");

    a_result_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !r_ovalid) |=> (r_ovalid && r_state == S_IDLE))
        else $error("A finished item was not loaded into a free output register.");

    a_delay_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADDR) |-> (sel_cur[DELAY_W-1] == 1'b0))
        else $error("The smoothed delay left the span of the store.");

    a_wp_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (r_wp == $past(r_wp) + 1'b1))
        else $error("The write position did not advance once per item.");

endmodule

`default_nettype wire
